[sv/mpool_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpool_pkg
// Shared constants, types and helpers of the streaming 2-D max pooling block.
// ----------------------------------------------------------------------------
package mpool_pkg;

  localparam int MAX_KERNEL = 8;
  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int PIXEL_BITS = 16;

  localparam int KROW_W     = $clog2(MAX_KERNEL);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int LINE_DEPTH = MAX_KERNEL * MAX_COLS;
  localparam int ADDR_W     = KROW_W + COL_W;

  // Clamped kernel/stride and plane size widths.
  localparam int KVAL_W = $clog2(MAX_KERNEL + 1);
  localparam int PVAL_W = (MAX_ROWS > MAX_COLS) ? $clog2(MAX_ROWS + 1) : $clog2(MAX_COLS + 1);

  // Raw register widths and configuration port.
  localparam int KREG_W    = 4;
  localparam int PREG_W    = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_COLS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_ROWS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COLS  = 3'd5;

  typedef logic signed [PIXEL_BITS-1:0] pixel_t;

  // Effective (clamped) configuration.
  typedef struct packed {
    logic [KVAL_W-1:0] kr;
    logic [KVAL_W-1:0] kc;
    logic [KVAL_W-1:0] sr;
    logic [KVAL_W-1:0] sc;
    logic [PVAL_W-1:0] pr;
    logic [PVAL_W-1:0] pc;
  } geom_t;

  // Position of the current pixel and what it completes.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             emit;
    logic             last;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
  } pos_info_t;

  function automatic logic [KVAL_W-1:0] clamp_k(input logic [KREG_W-1:0] v);
    logic [KVAL_W-1:0] res;
    if (v == '0) begin
      res = KVAL_W'(1);
    end else if (32'(v) > MAX_KERNEL) begin
      res = KVAL_W'(MAX_KERNEL);
    end else begin
      res = KVAL_W'(v);
    end
    return res;
  endfunction

  function automatic logic [PVAL_W-1:0] clamp_p(input logic [PREG_W-1:0] v,
                                                 input int top);
    logic [PVAL_W-1:0] res;
    if (v == '0) begin
      res = PVAL_W'(1);
    end else if (32'(v) > top) begin
      res = PVAL_W'(top);
    end else begin
      res = PVAL_W'(v);
    end
    return res;
  endfunction

endpackage

[sv/mpool_pos.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpool_pos
// Raster position, stride phases and output window counters of the plane.
// ----------------------------------------------------------------------------
module mpool_pos (
  input  logic               clk,
  input  logic               rst_n,
  input  mpool_pkg::geom_t   geom,
  input  logic               step,
  input  logic               restart,
  output mpool_pkg::pos_info_t info
);
  import mpool_pkg::*;

  localparam int SUM_W = PVAL_W + 1;

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [KROW_W-1:0] row_phase_r, row_phase_nxt;
  logic [KROW_W-1:0] col_phase_r, col_phase_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;

  logic [SUM_W-1:0] r1, c1, rp1, cp1;
  logic row_in, row_ok, col_in, emit, eol, eop, last;

  always_comb begin
    r1  = SUM_W'(row_r) + SUM_W'(1);
    c1  = SUM_W'(col_r) + SUM_W'(1);
    rp1 = SUM_W'(row_phase_r) + SUM_W'(1);
    cp1 = SUM_W'(col_phase_r) + SUM_W'(1);
    row_in = r1 >= SUM_W'(geom.kr);
    row_ok = row_in && (row_phase_r == '0);
    col_in = c1 >= SUM_W'(geom.kc);
    emit   = row_ok && col_in && (col_phase_r == '0);
    eol    = c1 >= SUM_W'(geom.pc);
    eop    = r1 >= SUM_W'(geom.pr);
    // A window is the last one when no further window start fits on either axis.
    last   = (SUM_W'(row_r) + SUM_W'(geom.sr) >= SUM_W'(geom.pr)) &&
             (SUM_W'(col_r) + SUM_W'(geom.sc) >= SUM_W'(geom.pc));
  end

  always_comb begin
    row_nxt       = row_r;
    col_nxt       = col_r;
    row_phase_nxt = row_phase_r;
    col_phase_nxt = col_phase_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    if (restart) begin
      row_nxt       = '0;
      col_nxt       = '0;
      row_phase_nxt = '0;
      col_phase_nxt = '0;
      out_row_nxt   = '0;
      out_col_nxt   = '0;
    end else if (step) begin
      if (eol) begin
        col_nxt       = '0;
        col_phase_nxt = '0;
        out_col_nxt   = '0;
        if (row_ok) begin
          out_row_nxt = out_row_r + ROW_W'(1);
        end
        if (row_in) begin
          row_phase_nxt = (rp1 >= SUM_W'(geom.sr)) ? '0 : row_phase_r + KROW_W'(1);
        end
        if (eop) begin
          row_nxt       = '0;
          row_phase_nxt = '0;
          out_row_nxt   = '0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
        if (col_in) begin
          col_phase_nxt = (cp1 >= SUM_W'(geom.sc)) ? '0 : col_phase_r + KROW_W'(1);
        end
        if (emit) begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      row_phase_r <= '0;
      col_phase_r <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      row_phase_r <= row_phase_nxt;
      col_phase_r <= col_phase_nxt;
      out_row_r   <= out_row_nxt;
      out_col_r   <= out_col_nxt;
    end
  end

  assign info.row     = row_r;
  assign info.col     = col_r;
  assign info.emit    = emit;
  assign info.last    = last;
  assign info.out_row = out_row_r;
  assign info.out_col = out_col_r;

endmodule

[sv/max_pool_2d_stream_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2d_stream_unit
// Streaming 2-D max pooling over raster-order planes using a line store.
// ----------------------------------------------------------------------------
// A pixel that completes no window leaves the input free for the next pixel;
// a pixel that completes a window holds in_stall high while the window is
// swept through the single read port of the line store, which delivers one
// window entry per cycle, and until its result enters the output register.
// The result waits in S_LOAD for as long as the output register is stalled.
// Reset: counters clear, registers return to 2,2,2,2,1024,1024; the line store
// is not cleared, since a window only reads entries written in its own plane.
module max_pool_2d_stream_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [mpool_pkg::PIXEL_BITS-1:0] in_pixel_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mpool_pkg::PIXEL_BITS-1:0] out_pooled_value,
  output logic [mpool_pkg::ROW_W-1:0]           out_out_row,
  output logic [mpool_pkg::COL_W-1:0]           out_out_col,
  output logic                                  out_last_of_plane,
  input  logic                                  cfg_wr_en,
  input  logic [mpool_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mpool_pkg::CFG_W-1:0]           cfg_data
);
  import mpool_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  // Configuration registers, raw as written.
  logic [KREG_W-1:0] kr_reg_r, kc_reg_r, sr_reg_r, sc_reg_r;
  logic [PREG_W-1:0] pr_reg_r, pc_reg_r;
  logic              cfg_hit;
  geom_t             geom;
  pos_info_t         pos;

  logic [1:0]        state_r, state_nxt;
  logic              accept;
  logic [KROW_W-1:0] base_row_r, dr_r;
  logic [COL_W-1:0]  base_col_r;
  logic [KROW_W-1:0] dc_r;
  logic [KVAL_W-1:0] kr_m1, kc_m1;
  pixel_t            best_r, best_cur;
  logic [ROW_W-1:0]  res_row_r;
  logic [COL_W-1:0]  res_col_r;
  logic              res_last_r;
  logic              out_free;

  pixel_t            line_store [LINE_DEPTH];
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [KROW_W-1:0] rd_row;
  logic [COL_W-1:0]  rd_col;
  pixel_t            rd_data_r;
  logic              rd_vld_r;

  logic              out_valid_r;
  pixel_t            out_value_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic              out_last_r;

  assign cfg_hit = cfg_wr_en && (cfg_index == CFG_KERNEL_ROWS || cfg_index == CFG_KERNEL_COLS ||
                                 cfg_index == CFG_STRIDE_ROWS || cfg_index == CFG_STRIDE_COLS ||
                                 cfg_index == CFG_PLANE_ROWS  || cfg_index == CFG_PLANE_COLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kr_reg_r <= KREG_W'(2);
      kc_reg_r <= KREG_W'(2);
      sr_reg_r <= KREG_W'(2);
      sc_reg_r <= KREG_W'(2);
      pr_reg_r <= PREG_W'(1024);
      pc_reg_r <= PREG_W'(1024);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KERNEL_ROWS: kr_reg_r <= cfg_data[KREG_W-1:0];
        CFG_KERNEL_COLS: kc_reg_r <= cfg_data[KREG_W-1:0];
        CFG_STRIDE_ROWS: sr_reg_r <= cfg_data[KREG_W-1:0];
        CFG_STRIDE_COLS: sc_reg_r <= cfg_data[KREG_W-1:0];
        CFG_PLANE_ROWS:  pr_reg_r <= cfg_data[PREG_W-1:0];
        CFG_PLANE_COLS:  pc_reg_r <= cfg_data[PREG_W-1:0];
        default: ;
      endcase
    end
  end

  assign geom.kr = clamp_k(kr_reg_r);
  assign geom.kc = clamp_k(kc_reg_r);
  assign geom.sr = clamp_k(sr_reg_r);
  assign geom.sc = clamp_k(sc_reg_r);
  assign geom.pr = clamp_p(pr_reg_r, MAX_ROWS);
  assign geom.pc = clamp_p(pc_reg_r, MAX_COLS);

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  mpool_pos u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .geom    (geom),
    .step    (accept),
    .restart (cfg_hit),
    .info    (pos)
  );

  // Line store: the pixel is written when accepted; window reads start on
  // the next cycle, so a read never meets a write to the same entry.
  assign wr_addr = {pos.row[KROW_W-1:0], pos.col};
  assign rd_row  = base_row_r - dr_r;
  assign rd_col  = base_col_r - COL_W'(dc_r);
  assign rd_addr = {rd_row, rd_col};

  always_ff @(posedge clk) begin
    if (accept) begin
      line_store[wr_addr] <= in_pixel_value;
    end
    rd_data_r <= line_store[rd_addr];
  end

  assign kr_m1 = geom.kr - KVAL_W'(1);
  assign kc_m1 = geom.kc - KVAL_W'(1);

  always_comb begin
    best_cur = best_r;
    if (rd_vld_r && (rd_data_r > best_r)) begin
      best_cur = rd_data_r;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && pos.emit) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (KVAL_W'(dc_r) == kc_m1 && KVAL_W'(dr_r) == kr_m1) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == S_READ);
    end
  end

  // Window sweep: rows outer, columns inner, one entry per cycle.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      dr_r <= '0;
      dc_r <= '0;
      if (accept && pos.emit) begin
        base_row_r <= pos.row[KROW_W-1:0];
        base_col_r <= pos.col;
        best_r     <= in_pixel_value;
        res_row_r  <= pos.out_row;
        res_col_r  <= pos.out_col;
        res_last_r <= pos.last;
      end
    end else begin
      best_r <= best_cur;
      if (state_r == S_READ) begin
        if (KVAL_W'(dc_r) == kc_m1) begin
          dc_r <= '0;
          dr_r <= dr_r + KROW_W'(1);
        end else begin
          dc_r <= dc_r + KROW_W'(1);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_LOAD && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD && out_free) begin
      out_value_r <= best_cur;
      out_row_r   <= res_row_r;
      out_col_r   <= res_col_r;
      out_last_r  <= res_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pooled_value  = out_value_r;
  assign out_out_row       = out_row_r;
  assign out_out_col       = out_col_r;
  assign out_last_of_plane = out_last_r;

  a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_LOAD))
    else $error("output word appeared without a finished window sweep");

  a_emit_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pos.emit) |=> (state_r == S_READ))
    else $error("completed window did not start a line store sweep");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD && out_valid_r && out_stall) |=> (state_r == S_LOAD))
    else $error("window result left while the output register was full");

endmodule

[bench/tb_max_pool_2d_stream_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_pool_2d_stream_unit
// Self-checking bench for the streaming 2-D max pooling unit. A short table of
// directed words covers the reset geometry, the register extremes, the case of
// a kernel larger than its plane, and the unused register indexes. Random
// phases follow, each with a fresh geometry and one or two planes of random
// pixels. The phases rotate through four idling patterns on the two channels.
// Every pooled word is checked field by field against an in-bench window model.
// ----------------------------------------------------------------------------
module tb_max_pool_2d_stream_unit;
  import mpool_pkg::*;

  localparam int SETTLE_CYCLES = MAX_KERNEL * MAX_KERNEL + 16;
  localparam int RANDOM_ITEMS  = 650;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum logic {STEP_CFG, STEP_PIXEL} step_kind_e;

  typedef struct packed {
    pixel_t           value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } pool_word_t;

  typedef struct {
    step_kind_e           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    pixel_t               px;
    bit                   typed;
    bit                   hit;
    pool_word_t           want;
  } dir_step_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  pixel_t               in_pixel_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  pixel_t               out_pooled_value;
  logic [ROW_W-1:0]     out_out_row;
  logic [COL_W-1:0]     out_out_col;
  logic                 out_last_of_plane;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  max_pool_2d_stream_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_value   (in_pixel_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pooled_value (out_pooled_value),
    .out_out_row      (out_out_row),
    .out_out_col      (out_out_col),
    .out_last_of_plane(out_last_of_plane),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Window model state: raw registers, line store and raster counters.
  logic [KREG_W-1:0] kr_reg = 4'd2, kc_reg = 4'd2, sr_reg = 4'd2, sc_reg = 4'd2;
  logic [PREG_W-1:0] pr_reg = 11'd1024, pc_reg = 11'd1024;
  pixel_t            line_mem [MAX_KERNEL][MAX_COLS];
  int                row_cnt, col_cnt, row_ph, col_ph, out_row_cnt, out_col_cnt;

  pool_word_t pending_pool [$];
  dir_step_t  dir_table [$];
  int         tx_pct = 0, rx_pct = 0;
  int         err_count = 0, words_checked = 0, pixels_sent = 0;
  int         dir_pixels = 0, reg_writes = 0, phase_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int eff_k(input logic [KREG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_KERNEL) return MAX_KERNEL;
    return int'(v);
  endfunction

  function automatic int eff_p(input logic [PREG_W-1:0] v, input int top);
    if (v == '0) return 1;
    if (v > top) return top;
    return int'(v);
  endfunction

  function automatic void restart_counts();
    row_cnt = 0; col_cnt = 0; row_ph = 0; col_ph = 0;
    out_row_cnt = 0; out_col_cnt = 0;
  endfunction

  function automatic void model_config(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] data);
    case (idx)
      CFG_KERNEL_ROWS: kr_reg = data[KREG_W-1:0];
      CFG_KERNEL_COLS: kc_reg = data[KREG_W-1:0];
      CFG_STRIDE_ROWS: sr_reg = data[KREG_W-1:0];
      CFG_STRIDE_COLS: sc_reg = data[KREG_W-1:0];
      CFG_PLANE_ROWS:  pr_reg = data[PREG_W-1:0];
      CFG_PLANE_COLS:  pc_reg = data[PREG_W-1:0];
      default:         return;
    endcase
    restart_counts();
  endfunction

  function automatic void pool_pixel(input pixel_t px, output bit hit, output pool_word_t w);
    int kr, kc, sr, sc, pr, pc, r, c, n_rows, n_cols, dr, dc;
    bit row_ok, col_in;
    pixel_t best;
    kr = eff_k(kr_reg); kc = eff_k(kc_reg);
    sr = eff_k(sr_reg); sc = eff_k(sc_reg);
    pr = eff_p(pr_reg, MAX_ROWS); pc = eff_p(pc_reg, MAX_COLS);
    r = row_cnt; c = col_cnt;
    row_ok = (r + 1 >= kr) && (row_ph == 0);
    col_in = (c + 1 >= kc);
    hit = 1'b0;
    w = '0;
    line_mem[r % MAX_KERNEL][c % MAX_COLS] = px;
    if (row_ok && col_in && col_ph == 0) begin
      best = px;
      n_rows = 1 + (pr - kr) / sr;
      n_cols = 1 + (pc - kc) / sc;
      for (dr = 0; dr < kr; dr++) begin
        for (dc = 0; dc < kc; dc++) begin
          if (line_mem[(r - dr) % MAX_KERNEL][(c - dc) % MAX_COLS] > best) begin
            best = line_mem[(r - dr) % MAX_KERNEL][(c - dc) % MAX_COLS];
          end
        end
      end
      w.value = best;
      w.row = ROW_W'(out_row_cnt);
      w.col = COL_W'(out_col_cnt);
      w.last = (out_row_cnt + 1 == n_rows) && (out_col_cnt + 1 == n_cols);
      out_col_cnt++;
      hit = 1'b1;
    end
    if (col_in) col_ph = (col_ph + 1 >= sc) ? 0 : col_ph + 1;
    if (c + 1 >= pc) begin
      if (row_ok) out_row_cnt++;
      if (r + 1 >= kr) row_ph = (row_ph + 1 >= sr) ? 0 : row_ph + 1;
      col_cnt = 0; col_ph = 0; out_col_cnt = 0;
      if (r + 1 >= pr) restart_counts();
      else row_cnt = r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    dir_table.push_back('{STEP_CFG, idx, data, '0, 1'b0, 1'b0, '0});
  endfunction

  function automatic void add_pix(input pixel_t px);
    dir_table.push_back('{STEP_PIXEL, '0, '0, px, 1'b0, 1'b0, '0});
  endfunction

  function automatic void add_typed(input pixel_t px, input bit hit, input pixel_t value,
                                    input logic last);
    pool_word_t w;
    w = '{value, '0, '0, last};
    dir_table.push_back('{STEP_PIXEL, '0, '0, px, 1'b1, hit, w});
  endfunction

  function automatic logic [KREG_W-1:0] pick_kreg();
    int roll;
    roll = $urandom_range(99);
    if (roll < 6) return '0;
    if (roll < 12) return KREG_W'($urandom_range(15, MAX_KERNEL + 1));
    return KREG_W'($urandom_range(MAX_KERNEL, 1));
  endfunction

  // Mostly planes that hold at least one window; a few too small for the kernel.
  function automatic logic [PREG_W-1:0] pick_preg(input int k);
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 12 && k > 1) return PREG_W'($urandom_range(k - 1, 1));
    return PREG_W'(k + $urandom_range(5, 0));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // Drops the channels to idle and waits until every pooled word is back,
  // plus enough cycles for a window read that is still under way.
  task automatic settle();
    in_valid <= 1'b0;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    while (pending_pool.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    model_config(idx, data);
    reg_writes++;
  endtask

  task automatic send_pixel(input pixel_t px);
    cfg_wr_en <= 1'b0;
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_value <= px;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  task automatic run_phase(input logic [KREG_W-1:0] kr_v, kc_v, sr_v, sc_v,
                           input logic [PREG_W-1:0] pr_v, pc_v,
                           input int planes, input bit cut, input idle_mode_e mode);
    logic [CFG_IDX_W-1:0] order [6];
    logic [CFG_W-1:0]     vals [6];
    int                   perm [6];
    int                   i, j, tmp, count, roll;
    pixel_t               px;
    bit                   hit;
    pool_word_t           w;
    settle();
    tx_pct = (mode == IDLE_SENDER) ? 53 : (mode == IDLE_BOTH) ? 12 : 0;
    rx_pct = (mode == IDLE_RECEIVER) ? 53 : (mode == IDLE_BOTH) ? 12 : 0;
    order = '{CFG_KERNEL_ROWS, CFG_KERNEL_COLS, CFG_STRIDE_ROWS, CFG_STRIDE_COLS,
              CFG_PLANE_ROWS, CFG_PLANE_COLS};
    // Upper data bits above a 4-bit register are random and must be ignored.
    vals = '{{7'($urandom), kr_v}, {7'($urandom), kc_v}, {7'($urandom), sr_v},
             {7'($urandom), sc_v}, pr_v, pc_v};
    for (i = 0; i < 6; i++) perm[i] = i;
    for (i = 5; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
    end
    if ($urandom_range(99) < 15) begin
      write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_W'($urandom));
    end
    for (i = 0; i < 6; i++) write_reg(order[perm[i]], vals[perm[i]]);
    count = eff_p(pr_v, MAX_ROWS) * eff_p(pc_v, MAX_COLS);
    // A cut phase may end inside a plane; the next write to a used register index restarts it.
    count = planes * count + (cut ? $urandom_range(count, 1) : 0);
    for (i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      px = (roll < 5) ? 16'sh7FFF : (roll < 10) ? 16'sh8000 : pixel_t'($urandom);
      send_pixel(px);
      pool_pixel(px, hit, w);
      if (hit) pending_pool.push_back(w);
    end
    phase_count++;
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_pct);
  end

  always @(posedge clk) begin : check_out
    pool_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pool.size() == 0) begin
        report_mismatch($sformatf("unexpected word value %0d at (%0d,%0d)",
                                  out_pooled_value, out_out_row, out_out_col));
      end else begin
        want = pending_pool.pop_front();
        if (out_pooled_value !== want.value)
          report_mismatch($sformatf("pooled_value %0d, expected %0d at (%0d,%0d)",
                                    out_pooled_value, want.value, want.row, want.col));
        if (out_out_row !== want.row)
          report_mismatch($sformatf("out_row %0d, expected %0d", out_out_row, want.row));
        if (out_out_col !== want.col)
          report_mismatch($sformatf("out_col %0d, expected %0d", out_out_col, want.col));
        if (out_last_of_plane !== want.last)
          report_mismatch($sformatf("last_of_plane %0b, expected %0b at (%0d,%0d)",
                                    out_last_of_plane, want.last, want.row, want.col));
        words_checked++;
      end
    end
  end

  initial begin
    int                i, phase, base;
    bit                hit;
    pool_word_t        w;
    logic [KREG_W-1:0] kr_v, kc_v, sr_v, sc_v;
    restart_counts();

    // Reset geometry is 2x2 over 1024 columns: the first row completes nothing.
    add_typed(16'sh7FFF, 1'b0, '0, 1'b0);
    add_typed(16'sh8000, 1'b0, '0, 1'b0);
    add_typed(16'sh0000, 1'b0, '0, 1'b0);
    add_typed(16'shFFFF, 1'b0, '0, 1'b0);
    // Zero acts as one and a value above the largest kernel acts as eight:
    // a 1x1 plane with a 1x1 window passes each pixel through as the last word.
    add_cfg(CFG_KERNEL_ROWS, 11'h000);
    add_cfg(CFG_KERNEL_COLS, 11'h7F1);
    add_cfg(CFG_STRIDE_ROWS, 11'h000);
    add_cfg(CFG_STRIDE_COLS, 11'h00F);
    add_cfg(CFG_PLANE_ROWS, 11'h000);
    add_cfg(CFG_PLANE_COLS, 11'h001);
    add_typed(16'sh8000, 1'b1, 16'sh8000, 1'b1);
    add_typed(16'sh7FFF, 1'b1, 16'sh7FFF, 1'b1);
    add_typed(16'sh5555, 1'b1, 16'sh5555, 1'b1);
    add_typed(16'shAAAA, 1'b1, 16'shAAAA, 1'b1);
    // An 8x8 kernel over a 4x4 plane never completes a window.
    add_cfg(CFG_KERNEL_ROWS, 11'h00F);
    add_cfg(CFG_KERNEL_COLS, 11'h008);
    add_cfg(CFG_PLANE_ROWS, 11'h004);
    add_cfg(CFG_PLANE_COLS, 11'h004);
    for (i = 0; i < 6; i++) add_typed(pixel_t'(16'sh1234 * i), 1'b0, '0, 1'b0);
    // Writes to the unused indexes in mid-plane must not restart the plane.
    add_cfg(CFG_KERNEL_ROWS, 11'h002);
    add_cfg(CFG_KERNEL_COLS, 11'h002);
    add_cfg(CFG_STRIDE_ROWS, 11'h001);
    add_cfg(CFG_STRIDE_COLS, 11'h001);
    add_cfg(CFG_PLANE_ROWS, 11'h002);
    add_cfg(CFG_PLANE_COLS, 11'h003);
    add_pix(16'sd5);
    add_pix(-16'sd3);
    add_pix(16'sd7);
    add_cfg(CFG_SPARE_LO, 11'h7FF);
    add_cfg(CFG_SPARE_HI, 11'h000);
    add_pix(-16'sd1);
    add_pix(16'sd9);
    add_pix(16'sh8000);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[k]) begin
      if (dir_table[k].kind == STEP_CFG) begin
        if (k == 0 || dir_table[k - 1].kind != STEP_CFG) settle();
        write_reg(dir_table[k].idx, dir_table[k].data);
      end else begin
        send_pixel(dir_table[k].px);
        pool_pixel(dir_table[k].px, hit, w);
        if (dir_table[k].typed) begin
          hit = dir_table[k].hit;
          w = dir_table[k].want;
        end
        if (hit) pending_pool.push_back(w);
        dir_pixels++;
      end
    end

    base = pixels_sent;
    phase = 0;
    while (pixels_sent - base < RANDOM_ITEMS || phase < 8) begin
      kr_v = pick_kreg();
      kc_v = pick_kreg();
      sr_v = pick_kreg();
      sc_v = pick_kreg();
      run_phase(kr_v, kc_v, sr_v, sc_v, pick_preg(eff_k(kr_v)), pick_preg(eff_k(kc_v)),
                $urandom_range(2, 1), ($urandom_range(99) < 20), idle_mode_e'(phase % 4));
      phase++;
    end

    settle();
    $display("Sent %0d pixel words (%0d directed) over %0d random geometries, %0d reg writes.",
             pixels_sent, dir_pixels, phase_count, reg_writes);
    $display("Checked %0d pooled words with %0d mismatches.", words_checked, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
